// File: src/zdf_ladder_lowpass_4pole_defines.svh
// Assertion helpers shared by the ladder filter RTL.
`ifndef ZDF_LADDER_LOWPASS_4POLE_DEFINES_SVH
`define ZDF_LADDER_LOWPASS_4POLE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ZDFLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ZDFLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/zdflp_pkg.sv
package zdflp_pkg;

    localparam int FRAC       = 28;
    localparam int CUTOFF_W   = 15;
    localparam int AMT_W      = 16;
    localparam int FS_W       = 18;
    localparam int MR_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int DVD_W  = 64;
    localparam int DVS_W  = 34;
    localparam int QUO_W  = 46;
    localparam int ITER_W = 7;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;

    localparam logic [29:0]          PI_Q28     = 30'd843314857;
    localparam logic [CUTOFF_W-1:0]  CUTOFF_MAX = 15'd20000;
    localparam logic [DVS_W-1:0]     ONE_Q28    = 34'd1 << FRAC;
    localparam logic [FS_W-1:0]      FS_RESET   = 18'd48000;
    localparam logic [MR_W-1:0]      MR_RESET   = 16'd16384;

    // quotient bits needed by each division
    localparam logic [ITER_W-1:0] ITER_GQ = 7'd46;
    localparam logic [ITER_W-1:0] ITER_G1 = 7'd29;
    localparam logic [ITER_W-1:0] ITER_H  = 7'd29;
    localparam logic [ITER_W-1:0] ITER_U  = 7'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_MAX_RES     = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [PROD_W-1:0] shr_trunc(
        input logic signed [PROD_W-1:0] v,
        input int                       n
    );
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((68'sd1 <<< n) - 68'sd1) : 68'sd0;
        return (v + bias) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: src/zdflp_if.sv
interface zdflp_in_if #(parameter int SAMPLE_WIDTH = 24);
    logic                                  valid;
    logic                                  ready;
    logic signed [SAMPLE_WIDTH-1:0]        sample_in;
    logic [zdflp_pkg::CUTOFF_W-1:0]        cutoff_hz;
    logic [zdflp_pkg::AMT_W-1:0]           resonance_amount;
    modport source (output valid, sample_in, cutoff_hz, resonance_amount, input ready);
    modport sink   (input valid, sample_in, cutoff_hz, resonance_amount, output ready);
endinterface

interface zdflp_out_if #(parameter int SAMPLE_WIDTH = 24);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

interface zdflp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [zdflp_pkg::CFG_IDX_W-1:0]    index;
    logic [zdflp_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/zdflp_div.sv
module zdflp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zdflp_pkg::t_div_req i_req,
    output zdflp_pkg::t_div_rsp o_rsp
);
    import zdflp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_W-1:0]    r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_dvd;
    logic [QUO_W-1:0]     r_quo;

    logic [DVS_W:0]       w_trial;
    logic [DVS_W:0]       w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // high part seeds the remainder, low part is fed in MSB first
            r_rem <= DVS_W'(i_req.dividend >> i_req.iters);
            r_dvd <= i_req.dividend << (7'd64 - i_req.iters);
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: src/zdf_ladder_lowpass_4pole.sv
// Channel  | Dir | Carries                                       | Handshake
// i_in     | in  | sample_in, cutoff_hz, resonance_amount        | valid/ready
// o_out    | out | sample_out                                    | valid/ready
// i_cfg    | in  | index (0 sample rate, 1 max resonance), data  | valid/ready, always ready
//
// One transaction runs as a sequence: four divisions on the shared one-bit-per-cycle divider
// and 18 products on the shared 34x34 multiplier, each issued, waited for and taken in turn
// (S_ISSUE, S_WAIT, S_TAKE); the output register is loaded last.
// i_rst_n is synchronous: filter states cleared, registers back to 48000 / 16384.
// Input is taken only while the sequencer is idle; a finished result holds until the
// output register is free.
`include "zdf_ladder_lowpass_4pole_defines.svh"

module zdf_ladder_lowpass_4pole #(
    parameter int NUM_STAGES   = 4,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    zdflp_in_if.sink      i_in,
    zdflp_out_if.source   o_out,
    zdflp_cfg_if.sink     i_cfg
);
    import zdflp_pkg::*;

    localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int SH    = 29 - SAMPLE_WIDTH;
    localparam logic signed [PROD_W-1:0] SMAX = (68'sd1 <<< (SAMPLE_WIDTH - 1)) - 68'sd1;
    localparam logic signed [PROD_W-1:0] SMIN = -(68'sd1 <<< (SAMPLE_WIDTH - 1));

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_TAKE, S_OUT} t_state;

    typedef enum logic [4:0] {
        OP_GQ_M, OP_GQ_D, OP_K_M, OP_G1_D, OP_H_D,
        OP_GP2, OP_GP3, OP_GBIG,
        OP_T0, OP_A0, OP_T1, OP_A1, OP_T2, OP_A2, OP_A3,
        OP_KS, OP_KG, OP_U_D, OP_V
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [STG_W-1:0] r_stg;

    logic [FS_W-1:0] r_fs;
    logic [MR_W-1:0] r_mr;

    logic signed [31:0]       r_x;
    logic [CUTOFF_W-1:0]      r_fc;
    logic [AMT_W-1:0]         r_amt;
    logic [30:0]              r_g;
    logic [28:0]              r_g1;
    logic [28:0]              r_h;
    logic [31:0]              r_k;
    logic [28:0]              r_gp2;
    logic [28:0]              r_gp3;
    logic [28:0]              r_gbig;
    logic signed [31:0]       r_t;
    logic signed [35:0]       r_acc;
    logic signed [31:0]       r_s;
    logic signed [31:0]       r_num;
    logic [DVS_W-1:0]         r_den;
    logic signed [31:0]       r_u;
    logic signed [31:0]       r_st [NUM_STAGES];

    logic signed [MUL_W-1:0]  r_ma;
    logic signed [MUL_W-1:0]  r_mb;
    logic signed [PROD_W-1:0] r_prod;

    logic                           r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_odata;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                     w_is_div;
    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [39:0]       w_mq;
    logic signed [32:0]       w_diff;
    logic [DVS_W-1:0]         w_g_den;
    logic [32:0]              w_num_mag;
    logic signed [33:0]       w_uq;
    logic signed [33:0]       w_u_sgn;
    logic signed [35:0]       w_accsum;
    logic signed [35:0]       w_v;
    logic signed [35:0]       w_y;
    logic signed [35:0]       w_s2;
    logic [31:0]              w_p;
    logic [15:0]              w_q0;
    logic [16:0]              w_rem;
    logic [32:0]              w_k;
    logic signed [PROD_W-1:0] w_xin;
    logic signed [PROD_W-1:0] w_xq;
    logic signed [PROD_W-1:0] w_oq;
    logic signed [PROD_W-1:0] w_oclamp;
    logic                     w_out_free;

    zdflp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_is_div   = (r_op inside {OP_GQ_D, OP_G1_D, OP_H_D, OP_U_D});
    assign w_mq       = 40'(shr_trunc(r_prod, FRAC));
    assign w_diff     = 33'(r_u) - 33'(r_st[r_stg]);
    assign w_g_den    = 34'(r_g) + ONE_Q28;
    assign w_num_mag  = r_num[31] ? 33'(-(33'(r_num))) : 33'(r_num);
    assign w_uq       = {2'b00, w_div_rsp.quotient[31:0]};
    assign w_u_sgn    = r_num[31] ? -w_uq : w_uq;
    assign w_accsum   = r_acc + w_mq[35:0];
    assign w_v        = w_mq[35:0];
    assign w_y        = w_v + 36'(r_st[r_stg]);
    assign w_s2       = w_y + w_v;
    assign w_out_free = !r_ovalid || o_out.ready;

    // k = P * 65536 / 65535 = P + P / 65535, quotient from P >> 16 plus correction
    assign w_p   = r_prod[31:0];
    assign w_q0  = w_p[31:16];
    assign w_rem = {1'b0, w_p[15:0]} + {1'b0, w_q0};
    assign w_k   = 33'(w_p) + 33'(w_q0)
                 + 33'(w_rem >= 17'd65535) + 33'(w_rem >= 17'd131070);

    always_comb begin
        w_xin = 68'(i_in.sample_in);
        if (SH >= 0) begin
            w_xq = w_xin <<< SH;
            w_oq = shr_trunc(68'(r_u), SH);
        end else begin
            w_xq = shr_trunc(w_xin, -SH);
            w_oq = 68'(r_u) <<< (-SH);
        end
        if (w_oq > SMAX) begin
            w_oclamp = SMAX;
        end else if (w_oq < SMIN) begin
            w_oclamp = SMIN;
        end else begin
            w_oclamp = w_oq;
        end
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_op)
            OP_GQ_M: begin w_ma = 34'(PI_Q28);    w_mb = 34'(r_fc);   end
            OP_K_M:  begin w_ma = 34'(r_mr);      w_mb = 34'(r_amt);  end
            OP_GP2:  begin w_ma = 34'(r_g1);      w_mb = 34'(r_g1);   end
            OP_GP3:  begin w_ma = 34'(r_gp2);     w_mb = 34'(r_g1);   end
            OP_GBIG: begin w_ma = 34'(r_gp3);     w_mb = 34'(r_g1);   end
            OP_T0:   begin w_ma = 34'(r_st[0]);   w_mb = 34'(r_h);    end
            OP_A0:   begin w_ma = 34'(r_gp3);     w_mb = 34'(r_t);    end
            OP_T1:   begin w_ma = 34'(r_st[1]);   w_mb = 34'(r_h);    end
            OP_A1:   begin w_ma = 34'(r_gp2);     w_mb = 34'(r_t);    end
            OP_T2:   begin w_ma = 34'(r_st[2]);   w_mb = 34'(r_h);    end
            OP_A2:   begin w_ma = 34'(r_g1);      w_mb = 34'(r_t);    end
            OP_A3:   begin w_ma = 34'(r_st[3]);   w_mb = 34'(r_h);    end
            OP_KS:   begin w_ma = 34'(r_k);       w_mb = 34'(r_s);    end
            OP_KG:   begin w_ma = 34'(r_k);       w_mb = 34'(r_gbig); end
            OP_V:    begin w_ma = 34'(w_diff);    w_mb = 34'(r_g1);   end
            default: begin w_ma = '0;             w_mb = '0;          end
        endcase
    end

    always_comb begin
        w_div_req.start    = (r_state == S_ISSUE) && w_is_div;
        w_div_req.dividend = '0;
        w_div_req.divisor  = 34'd1;
        w_div_req.iters    = ITER_GQ;
        case (r_op)
            OP_GQ_D: begin
                w_div_req.dividend = 64'(r_prod[44:0]);
                w_div_req.divisor  = (r_fs == '0) ? 34'd1 : 34'(r_fs);
                w_div_req.iters    = ITER_GQ;
            end
            OP_G1_D: begin
                w_div_req.dividend = 64'({r_g, 28'd0});
                w_div_req.divisor  = w_g_den;
                w_div_req.iters    = ITER_G1;
            end
            OP_H_D: begin
                w_div_req.dividend = 64'd1 << (2 * FRAC);
                w_div_req.divisor  = w_g_den;
                w_div_req.iters    = ITER_H;
            end
            OP_U_D: begin
                w_div_req.dividend = 64'({w_num_mag, 28'd0});
                w_div_req.divisor  = r_den;
                w_div_req.iters    = ITER_U;
            end
            default: begin
                w_div_req.dividend = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_GQ_M;
            r_stg    <= '0;
            r_fs     <= FS_RESET;
            r_mr     <= MR_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_st[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_SAMPLE_RATE: r_fs <= i_cfg.data;
                    CFG_MAX_RES:     r_mr <= i_cfg.data[MR_W-1:0];
                    default:         ;
                endcase
            end
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x     <= w_xq[31:0];
                        r_fc    <= (i_in.cutoff_hz > CUTOFF_MAX) ? CUTOFF_MAX
                                                                  : i_in.cutoff_hz;
                        r_amt   <= i_in.resonance_amount;
                        r_op    <= OP_GQ_M;
                        r_stg   <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_ma    <= w_ma;
                    r_mb    <= w_mb;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!w_is_div || w_div_rsp.done) begin
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    r_state <= S_ISSUE;
                    r_op    <= t_op'(r_op + 5'd1);
                    case (r_op)
                        OP_GQ_D: r_g <= (w_div_rsp.quotient > 46'h7FFFFFFF)
                                        ? 31'h7FFFFFFF : w_div_rsp.quotient[30:0];
                        OP_K_M:  r_k    <= w_k[31:0];
                        OP_G1_D: r_g1   <= w_div_rsp.quotient[28:0];
                        OP_H_D:  r_h    <= w_div_rsp.quotient[28:0];
                        OP_GP2:  r_gp2  <= w_mq[28:0];
                        OP_GP3:  r_gp3  <= w_mq[28:0];
                        OP_GBIG: r_gbig <= w_mq[28:0];
                        OP_T0, OP_T1, OP_T2: r_t <= w_mq[31:0];
                        OP_A0:   r_acc  <= w_mq[35:0];
                        OP_A1, OP_A2: r_acc <= w_accsum;
                        OP_A3:   r_s    <= sat32(68'(w_accsum));
                        OP_KS:   r_num  <= sat32(68'(r_x) - 68'(w_mq));
                        OP_KG:   r_den  <= ONE_Q28 + w_mq[33:0];
                        OP_U_D:  r_u    <= sat32(68'(w_u_sgn));
                        OP_V: begin
                            r_st[r_stg] <= sat32(68'(w_s2));
                            r_u         <= sat32(68'(w_y));
                            // stay on the stage product until the last stage is done
                            r_op        <= OP_V;
                            if (r_stg == STG_W'(NUM_STAGES - 1)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_stg <= r_stg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= w_oclamp[SAMPLE_WIDTH-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_odata;

    `ZDFLP_ASSERT_NEXT(a_accept_starts, i_in.valid && i_in.ready, r_state == S_ISSUE && r_op == OP_GQ_M, "accepted sample did not start the sequence")
    `ZDFLP_ASSERT_IMP(a_div_done_in_wait, w_div_rsp.done, r_state == S_WAIT && w_is_div, "divider finished outside a division wait")
    `ZDFLP_ASSERT_NEXT(a_out_loaded, r_state == S_OUT && !o_out.valid, o_out.valid && r_state == S_IDLE, "free output register not loaded")

endmodule
